FILE: hw/rtl/cell_volume_relaxation_step_core_assert.svh
// Assertion macros used by the cvr_chk checker.
`ifndef CELL_VOLUME_RELAXATION_STEP_CORE_ASSERT_SVH
`define CELL_VOLUME_RELAXATION_STEP_CORE_ASSERT_SVH

// Same-cycle implication.
`define CVR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cvr check failed");

// Next-cycle implication.
`define CVR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cvr check failed");

`endif

FILE: hw/rtl/cvr_pkg.sv
package cvr_pkg;

  localparam int CELL_COUNT = 1024;
  localparam int IDX_W      = $clog2(CELL_COUNT);
  localparam int VOL_W      = 32;
  localparam int FRAC_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [VOL_W-1:0]  MAX_VOL = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP,
    REG_FLUID_RATE,
    REG_NUCLEAR_SOLID_RATE,
    REG_CYTOPLASMIC_SOLID_RATE,
    REG_CALCIFY_RATE,
    REG_GOAL_FLUID_FRACTION,
    REG_GOAL_NUCLEAR_SOLID,
    REG_GOAL_CYTO_TO_NUCLEAR
  } cvr_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCS,
    ST_GCS2,
    ST_K,
    ST_PH,
    ST_PL,
    ST_RC,
    ST_NF,
    ST_NFD,
    ST_NFW,
    ST_TAIL,
    ST_FSD,
    ST_FSW,
    ST_WB
  } cvr_state_e;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  cell_index;
    logic [VOL_W-1:0]  load_fluid;
    logic [VOL_W-1:0]  load_nuclear_solid;
    logic [VOL_W-1:0]  load_cytoplasmic_solid;
    logic [VOL_W-1:0]  load_nuclear_fluid;
    logic [FRAC_W-1:0] load_calcified;
  } cvr_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  out_index;
    logic [VOL_W-1:0]  new_fluid;
    logic [VOL_W-1:0]  new_nuclear_solid;
    logic [VOL_W-1:0]  new_cytoplasmic_solid;
    logic [VOL_W-1:0]  nuclear_volume;
    logic [VOL_W-1:0]  cytoplasmic_volume;
    logic [VOL_W-1:0]  total_volume;
    logic [FRAC_W-1:0] fluid_share;
    logic [FRAC_W-1:0] calcified_share;
    logic [VOL_W-1:0]  goal_cytoplasmic_solid;
  } cvr_out_t;

  typedef struct packed {
    logic [VOL_W-1:0]  fluid;
    logic [VOL_W-1:0]  solid_nuc;
    logic [VOL_W-1:0]  solid_cyto;
    logic [VOL_W-1:0]  nuclear;
    logic [VOL_W-1:0]  total;
    logic [FRAC_W-1:0] calcified;
  } cvr_entry_t;

  typedef struct packed {
    logic             start;
    logic [63:0]      dividend;
    logic [VOL_W-1:0] divisor;
  } cvr_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } cvr_div_rsp_t;

  function automatic logic [FRAC_W-1:0] clamp_one(input logic [FRAC_W-1:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  function automatic logic [VOL_W-1:0] sat_add(input logic [VOL_W-1:0] a,
                                               input logic [VOL_W-1:0] b);
    logic [VOL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VOL_W] ? MAX_VOL : s[VOL_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/cvr_if.sv
interface cvr_in_if import cvr_pkg::*; ();
  logic    valid;
  logic    ready;
  cvr_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cvr_out_if import cvr_pkg::*; ();
  logic     valid;
  logic     ready;
  cvr_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cell_volume_relaxation_step_core.sv
// Flow: one item at a time; a zero total skips its division (the old total for nuclear
// fluid, the new total for fluid share). Input is ready again as soon as the result
// registers, and stays low while the output stalls. The radix-2 divider (up to twice
// per item) and the shared 32x32 multiplier (15 uses per step item) do the arithmetic.
// Reset: config to defaults, table not cleared.
module cell_volume_relaxation_step_core import cvr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cvr_in_if.sink                in_i,
  cvr_out_if.source             out_o
);
  cvr_state_e state_q, state_d;

  logic [15:0]       time_step_q;
  logic [VOL_W-1:0]  fluid_rate_q, ns_rate_q, cs_rate_q, calc_rate_q;
  logic [FRAC_W-1:0] goal_ff_q;
  logic [VOL_W-1:0]  goal_ns_q;
  logic [23:0]       goal_ratio_q;

  cvr_in_t           in_q;
  cvr_entry_t        old_q;
  cvr_entry_t        rdata;
  cvr_entry_t        wdata;
  logic [63:0]       prod_q;
  logic [23:0]       k_q;
  logic [55:0]       ph_q;
  logic [1:0]        ridx_q;
  logic [VOL_W-1:0]  goal_cs_q, target_q;
  logic [VOL_W-1:0]  fluid_n_q, ns_n_q, cs_n_q, nf_q;
  logic [FRAC_W-1:0] calc_n_q, share_q;
  logic [VOL_W-1:0]  nuc_q, cyto_q, tot_q;
  logic              out_valid_q;
  cvr_out_t          out_q;

  logic              accept;
  logic              wb_go;
  logic [VOL_W-1:0]  mul_a, mul_b;
  logic [VOL_W-1:0]  rel_old, rel_goal, rel_rate, mag, rel_res;
  logic              rel_neg;
  logic [80:0]       sum81;
  logic [40:0]       delta;
  logic [41:0]       pos_sum;
  logic [VOL_W-1:0]  cf, nuc_c, cyto_c;
  cvr_div_req_t      div_req;
  cvr_div_rsp_t      div_rsp;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign wb_go       = (state_q == ST_WB) && (!out_valid_q || out_o.ready);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  cvr_ram #(
    .Width($bits(cvr_entry_t)),
    .Depth(CELL_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wb_go),
    .waddr_i (in_q.cell_index),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (in_i.data.cell_index),
    .rdata_o (rdata)
  );

  cvr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q  <= 16'd1536;
      fluid_rate_q <= '0;
      ns_rate_q    <= '0;
      cs_rate_q    <= '0;
      calc_rate_q  <= '0;
      goal_ff_q    <= 17'd49152;
      goal_ns_q    <= '0;
      goal_ratio_q <= '0;
    end else if (cfg_we_i) begin
      case (cvr_reg_e'(cfg_idx_i))
        REG_TIME_STEP:              time_step_q  <= cfg_data_i[15:0];
        REG_FLUID_RATE:             fluid_rate_q <= cfg_data_i;
        REG_NUCLEAR_SOLID_RATE:     ns_rate_q    <= cfg_data_i;
        REG_CYTOPLASMIC_SOLID_RATE: cs_rate_q    <= cfg_data_i;
        REG_CALCIFY_RATE:           calc_rate_q  <= cfg_data_i;
        REG_GOAL_FLUID_FRACTION:    goal_ff_q    <= cfg_data_i[FRAC_W-1:0];
        REG_GOAL_NUCLEAR_SOLID:     goal_ns_q    <= cfg_data_i;
        REG_GOAL_CYTO_TO_NUCLEAR:   goal_ratio_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // relaxation operands for the current quantity
  always_comb begin
    case (ridx_q)
      2'd0: begin
        rel_old = old_q.fluid; rel_goal = target_q; rel_rate = fluid_rate_q;
      end
      2'd1: begin
        rel_old = old_q.solid_nuc; rel_goal = goal_ns_q; rel_rate = ns_rate_q;
      end
      2'd2: begin
        rel_old = old_q.solid_cyto; rel_goal = goal_cs_q; rel_rate = cs_rate_q;
      end
      default: begin
        rel_old  = {15'd0, clamp_one(old_q.calcified)};
        rel_goal = {15'd0, ONE_Q16};
        rel_rate = calc_rate_q;
      end
    endcase
    rel_neg = rel_goal < rel_old;
    mag     = rel_neg ? rel_old - rel_goal : rel_goal - rel_old;
    sum81   = {1'b0, ph_q, 24'd0} + {17'd0, prod_q};
    delta   = sum81[80:40];
    pos_sum = {10'd0, rel_old} + {1'b0, delta};
    if (rel_neg) begin
      rel_res = ({9'd0, rel_old} < delta) ? '0 : rel_old - delta[VOL_W-1:0];
    end else begin
      rel_res = (pos_sum > {10'd0, MAX_VOL}) ? MAX_VOL : pos_sum[VOL_W-1:0];
    end
  end

  assign cf     = (fluid_n_q > nf_q) ? fluid_n_q - nf_q : '0;
  assign nuc_c  = sat_add(ns_n_q, nf_q);
  assign cyto_c = sat_add(cs_n_q, cf);

  always_comb begin
    state_d          = state_q;
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = {32'd0, fluid_n_q} << 16;
    div_req.divisor  = tot_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_GCS;
      ST_GCS: begin
        mul_a   = {8'd0, goal_ratio_q};
        mul_b   = goal_ns_q;
        state_d = ST_GCS2;
      end
      ST_GCS2: begin
        mul_a   = {15'd0, clamp_one(goal_ff_q)};
        mul_b   = old_q.total;
        state_d = in_q.kind ? ST_K : ST_TAIL;
      end
      ST_K: begin
        mul_a   = {16'd0, time_step_q};
        mul_b   = rel_rate;
        state_d = ST_PH;
      end
      ST_PH: begin
        mul_a   = {8'd0, prod_q[47:24]};
        mul_b   = mag;
        state_d = ST_PL;
      end
      ST_PL: begin
        mul_a   = {8'd0, k_q};
        mul_b   = mag;
        state_d = ST_RC;
      end
      ST_RC: state_d = (ridx_q == 2'd3) ? ST_NF : ST_K;
      ST_NF: begin
        mul_a   = old_q.nuclear;
        mul_b   = fluid_n_q;
        state_d = (old_q.total == '0) ? ST_TAIL : ST_NFD;
      end
      ST_NFD: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = old_q.total;
        state_d          = ST_NFW;
      end
      ST_NFW: if (div_rsp.done) state_d = ST_TAIL;
      ST_TAIL: state_d = ST_FSD;
      ST_FSD: begin
        div_req.start = (tot_q != '0);
        state_d       = (tot_q == '0) ? ST_WB : ST_FSW;
      end
      ST_FSW: if (div_rsp.done) state_d = ST_WB;
      ST_WB: if (wb_go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ridx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        ridx_q <= '0;
      end else if (state_q == ST_RC) begin
        ridx_q <= ridx_q + 2'd1;
      end
      if (wb_go) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (accept) begin
      in_q      <= in_i.data;
      fluid_n_q <= in_i.data.load_fluid;
      ns_n_q    <= in_i.data.load_nuclear_solid;
      cs_n_q    <= in_i.data.load_cytoplasmic_solid;
      nf_q      <= in_i.data.load_nuclear_fluid;
      calc_n_q  <= clamp_one(in_i.data.load_calcified);
    end
    case (state_q)
      ST_GCS:  old_q <= rdata;
      ST_GCS2: goal_cs_q <= (prod_q[63:48] != '0) ? MAX_VOL : prod_q[47:16];
      ST_K:    if (ridx_q == 2'd0) target_q <= prod_q[47:16];
      ST_PH:   k_q <= prod_q[23:0];
      ST_PL:   ph_q <= prod_q[55:0];
      ST_RC: begin
        case (ridx_q)
          2'd0: fluid_n_q <= rel_res;
          2'd1: ns_n_q    <= rel_res;
          2'd2: cs_n_q    <= rel_res;
          default: calc_n_q <= (rel_res > {15'd0, ONE_Q16}) ? ONE_Q16
                                                            : rel_res[FRAC_W-1:0];
        endcase
      end
      ST_NF:   if (old_q.total == '0) nf_q <= '0;
      ST_NFW: begin
        if (div_rsp.done) begin
          nf_q <= (div_rsp.quotient[63:32] != '0) ? MAX_VOL : div_rsp.quotient[31:0];
        end
      end
      ST_TAIL: begin
        nuc_q  <= nuc_c;
        cyto_q <= cyto_c;
        tot_q  <= sat_add(nuc_c, cyto_c);
      end
      ST_FSD:  if (tot_q == '0) share_q <= '0;
      ST_FSW: begin
        if (div_rsp.done) begin
          share_q <= (div_rsp.quotient > 64'd65536) ? ONE_Q16
                                                    : div_rsp.quotient[FRAC_W-1:0];
        end
      end
      default: ;
    endcase
    if (wb_go) begin
      out_q.out_index              <= in_q.cell_index;
      out_q.new_fluid              <= fluid_n_q;
      out_q.new_nuclear_solid      <= ns_n_q;
      out_q.new_cytoplasmic_solid  <= cs_n_q;
      out_q.nuclear_volume         <= nuc_q;
      out_q.cytoplasmic_volume     <= cyto_q;
      out_q.total_volume           <= tot_q;
      out_q.fluid_share            <= share_q;
      out_q.calcified_share        <= calc_n_q;
      out_q.goal_cytoplasmic_solid <= goal_cs_q;
    end
  end

  assign wdata.fluid      = fluid_n_q;
  assign wdata.solid_nuc  = ns_n_q;
  assign wdata.solid_cyto = cs_n_q;
  assign wdata.nuclear    = nuc_q;
  assign wdata.total      = tot_q;
  assign wdata.calcified  = calc_n_q;
endmodule

FILE: hw/rtl/cvr_ram.sv
module cvr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: hw/rtl/cvr_div.sv
module cvr_div import cvr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cvr_div_req_t req_i,
  output cvr_div_rsp_t rsp_o
);
  logic [63:0]      quo_q;
  logic [VOL_W-1:0] rem_q;
  logic [VOL_W-1:0] dvs_q;
  logic [5:0]       cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [VOL_W:0]   rs;
  logic             ge;
  logic [VOL_W:0]   diff;

  assign rs   = {rem_q, quo_q[63]};
  assign ge   = rs >= {1'b0, dvs_q};
  assign diff = rs - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], ge};
      rem_q <= ge ? diff[VOL_W-1:0] : rs[VOL_W-1:0];
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

FILE: hw/rtl/cvr_chk.sv
`include "cell_volume_relaxation_step_core_assert.svh"

module cvr_chk import cvr_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid,
  input logic     out_ready,
  input cvr_out_t out_data
);
  `CVR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `CVR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data))
  `CVR_ASSERT_NOW(a_share_range, out_valid, out_data.fluid_share <= ONE_Q16)
  `CVR_ASSERT_NOW(a_calc_range, out_valid, out_data.calcified_share <= ONE_Q16)
  `CVR_ASSERT_NOW(a_zero_total, out_valid && out_data.total_volume == '0, out_data.fluid_share == '0)
endmodule

bind cell_volume_relaxation_step_core cvr_chk u_cvr_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.data)
);

FILE: tb/cell_volume_relaxation_step_core_tb.sv
module cell_volume_relaxation_step_core_tb;
  import cvr_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_HOLD = 400;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  cvr_in_if in_ch ();
  cvr_out_if out_ch ();

  cell_volume_relaxation_step_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i(in_ch),
    .out_o(out_ch)
  );

  // predictor state
  logic [31:0] cfg_regs [8];
  logic [31:0] fluid_tab [CELL_COUNT];
  logic [31:0] nsolid_tab [CELL_COUNT];
  logic [31:0] csolid_tab [CELL_COUNT];
  logic [31:0] nuc_tab [CELL_COUNT];
  logic [31:0] total_tab [CELL_COUNT];
  logic [16:0] calc_tab [CELL_COUNT];
  bit loaded_map [CELL_COUNT];
  int loaded_cells [$];

  cvr_out_t pending_volumes [$];
  int mismatches;
  int idle_cycles;
  bit no_idle;
  bit long_hold_req;

  initial begin
    clk_i = 1'b0;
  end
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] sat_vol(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [16:0] frac_limit(logic [63:0] v);
    return (v > 64'd65536) ? 17'd65536 : v[16:0];
  endfunction

  function automatic logic [63:0] gain_scale(logic [47:0] k, logic [63:0] m);
    logic [127:0] p;
    p = 128'(k) * 128'(m);
    return 64'(p >> 40);
  endfunction

  function automatic logic [31:0] relax_toward(logic [31:0] old, logic [31:0] goal,
                                               logic [47:0] k);
    longint o, d, delta, r;
    o = longint'({32'b0, old});
    d = longint'({32'b0, goal}) - o;
    delta = longint'(gain_scale(k, 64'(d < 0 ? -d : d)));
    r = (d < 0) ? o - delta : o + delta;
    if (r < 0) return '0;
    return sat_vol(64'(r));
  endfunction

  function automatic logic [47:0] gain_of(cvr_reg_e rate);
    return 48'(cfg_regs[REG_TIME_STEP][15:0]) * 48'(cfg_regs[rate]);
  endfunction

  function automatic cvr_out_t advance_cell(cvr_in_t it);
    cvr_out_t r;
    int idx;
    logic [31:0] fl, ns, cs, nf, cf, nuc, cyto, tot, gcs, target, o_tot, o_nuc;
    logic [16:0] calc;
    logic [63:0] t64;
    idx = int'(it.cell_index) % CELL_COUNT;
    gcs = sat_vol((64'(cfg_regs[REG_GOAL_CYTO_TO_NUCLEAR][23:0]) *
                   64'(cfg_regs[REG_GOAL_NUCLEAR_SOLID])) >> 16);
    if (it.kind == 1'b0) begin
      fl = it.load_fluid;
      ns = it.load_nuclear_solid;
      cs = it.load_cytoplasmic_solid;
      nf = it.load_nuclear_fluid;
      calc = frac_limit(64'(it.load_calcified));
    end else begin
      o_tot = total_tab[idx];
      o_nuc = nuc_tab[idx];
      t64 = 64'(frac_limit(64'(cfg_regs[REG_GOAL_FLUID_FRACTION][16:0]))) * 64'(o_tot);
      target = 32'(t64 >> 16);
      fl = relax_toward(fluid_tab[idx], target, gain_of(REG_FLUID_RATE));
      nf = (o_tot == 0) ? '0 : sat_vol((64'(o_nuc) * 64'(fl)) / 64'(o_tot));
      ns = relax_toward(nsolid_tab[idx], cfg_regs[REG_GOAL_NUCLEAR_SOLID],
                        gain_of(REG_NUCLEAR_SOLID_RATE));
      cs = relax_toward(csolid_tab[idx], gcs, gain_of(REG_CYTOPLASMIC_SOLID_RATE));
      calc = frac_limit(64'(calc_tab[idx]));
      calc = frac_limit(64'(calc) +
                        gain_scale(gain_of(REG_CALCIFY_RATE), 64'(17'd65536 - calc)));
    end
    cf = (fl > nf) ? fl - nf : '0;
    nuc = sat_vol(64'(ns) + 64'(nf));
    cyto = sat_vol(64'(cs) + 64'(cf));
    tot = sat_vol(64'(nuc) + 64'(cyto));
    fluid_tab[idx] = fl;
    nsolid_tab[idx] = ns;
    csolid_tab[idx] = cs;
    nuc_tab[idx] = nuc;
    total_tab[idx] = tot;
    calc_tab[idx] = calc;
    if (!loaded_map[idx]) begin
      loaded_map[idx] = 1'b1;
      loaded_cells.push_back(idx);
    end
    r.out_index = idx[IDX_W-1:0];
    r.new_fluid = fl;
    r.new_nuclear_solid = ns;
    r.new_cytoplasmic_solid = cs;
    r.nuclear_volume = nuc;
    r.cytoplasmic_volume = cyto;
    r.total_volume = tot;
    r.fluid_share = (tot == 0) ? '0 : frac_limit((64'(fl) << 16) / 64'(tot));
    r.calcified_share = calc;
    r.goal_cytoplasmic_solid = gcs;
    return r;
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [31:0] rand_vol();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom >> $urandom_range(0, 28);
    endcase
  endfunction

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return $urandom;
      default: return $urandom >> $urandom_range(4, 31);
    endcase
  endfunction

  task automatic send_item(cvr_in_t it);
    repeat (draw_wait() + 1) @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    pending_volumes.push_back(advance_cell(it));
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
  endtask

  task automatic load_cell(int idx, logic [31:0] fl, logic [31:0] ns, logic [31:0] cs,
                           logic [31:0] nf, logic [16:0] calc);
    cvr_in_t it;
    it.kind = 1'b0;
    it.cell_index = idx[IDX_W-1:0];
    it.load_fluid = fl;
    it.load_nuclear_solid = ns;
    it.load_cytoplasmic_solid = cs;
    it.load_nuclear_fluid = nf;
    it.load_calcified = calc;
    send_item(it);
  endtask

  task automatic step_cell(int idx);
    cvr_in_t it;
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(cvr_in_t)-1:0];
    it.kind = 1'b1;
    it.cell_index = idx[IDX_W-1:0];
    send_item(it);
  endtask

  task automatic wait_drained();
    while (pending_volumes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_config(logic [31:0] v [8]);
    wait_drained();
    for (int i = 0; i < 8; i++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= cvr_reg_e'(i);
      cfg_data_i <= v[i];
      cfg_regs[i] = v[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_load_extremes();
    load_cell(0, '0, '0, '0, '0, '0);
    load_cell(1, '1, '1, '1, '1, 17'h1FFFF);
    load_cell(2, 32'h0000_1000, 32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 17'd65536);
    load_cell(3, 32'h0040_0000, 32'h0010_0000, 32'h0030_0000, 32'h0010_0000, 17'd100);
    load_cell(1023, 32'h0008_0000, 32'h0004_0000, 32'h0006_0000, 32'h0001_0000, 17'd65535);
    load_cell(4, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 17'd32768);
  endtask

  task automatic test_step_special();
    logic [31:0] v [8];
    step_cell(0);
    step_cell(3);
    v = '{32'h0000_FFFF, '1, '1, '1, '1, 32'h0001_FFFF, '1, 32'h00FF_FFFF};
    write_config(v);
    step_cell(1);
    step_cell(2);
    step_cell(3);
    step_cell(4);
    step_cell(0);
    step_cell(1023);
    v = '{32'd1536, 32'd40_000_000, 32'd20_000_000, 32'd30_000_000, 32'd5_000_000,
          32'd49152, 32'h0020_0000, 32'h0002_0000};
    write_config(v);
    repeat (4) step_cell(3);
    step_cell(1023);
  endtask

  task automatic test_output_backpressure();
    long_hold_req = 1'b1;
    repeat (6) step_cell(loaded_cells[$urandom_range(0, loaded_cells.size() - 1)]);
  endtask

  task automatic test_sender_pause();
    repeat (5) step_cell(3);
    while (pending_volumes.size() != 0) @(posedge clk_i);
    repeat (5) step_cell(1023);
  endtask

  task automatic test_random_phase(int mode, int count);
    logic [31:0] v [8];
    for (int i = 0; i < 8; i++) begin
      case (mode)
        0: v[i] = '0;
        1: v[i] = '1;
        2: v[i] = $urandom;
        default: v[i] = rand_rate();
      endcase
    end
    if (mode >= 3) begin
      v[REG_TIME_STEP] = $urandom_range(0, 4096);
      v[REG_GOAL_FLUID_FRACTION] = $urandom_range(0, 70000);
      v[REG_GOAL_NUCLEAR_SOLID] = rand_vol();
      v[REG_GOAL_CYTO_TO_NUCLEAR] = $urandom_range(0, 1 << 20);
    end
    write_config(v);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (loaded_cells.size() == 0 || $urandom_range(0, 9) < 3) begin
        load_cell($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 1023),
                  rand_vol(), rand_vol(), rand_vol(), rand_vol(),
                  $urandom_range(0, 3) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536)));
      end else begin
        step_cell(loaded_cells[$urandom_range(0, loaded_cells.size() - 1)]);
      end
    end
    no_idle = 1'b0;
  endtask

  // receiver
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = draw_wait();
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // result check
  always @(posedge clk_i) begin
    cvr_out_t exp_beat;
    cvr_out_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_volumes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %h", got);
      end else begin
        exp_beat = pending_volumes.pop_front();
        if (got.out_index !== exp_beat.out_index ||
            got.new_fluid !== exp_beat.new_fluid ||
            got.new_nuclear_solid !== exp_beat.new_nuclear_solid ||
            got.new_cytoplasmic_solid !== exp_beat.new_cytoplasmic_solid ||
            got.nuclear_volume !== exp_beat.nuclear_volume ||
            got.cytoplasmic_volume !== exp_beat.cytoplasmic_volume ||
            got.total_volume !== exp_beat.total_volume ||
            got.fluid_share !== exp_beat.fluid_share ||
            got.calcified_share !== exp_beat.calcified_share ||
            got.goal_cytoplasmic_solid !== exp_beat.goal_cytoplasmic_solid) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp idx %0d fl %h ns %h cs %h nuc %h cyt %h tot %h fs %h ca %h gc %h",
                     exp_beat.out_index, exp_beat.new_fluid, exp_beat.new_nuclear_solid,
                     exp_beat.new_cytoplasmic_solid, exp_beat.nuclear_volume,
                     exp_beat.cytoplasmic_volume, exp_beat.total_volume,
                     exp_beat.fluid_share, exp_beat.calcified_share,
                     exp_beat.goal_cytoplasmic_solid);
            $display("         got idx %0d fl %h ns %h cs %h nuc %h cyt %h tot %h fs %h ca %h gc %h",
                     got.out_index, got.new_fluid, got.new_nuclear_solid,
                     got.new_cytoplasmic_solid, got.nuclear_volume,
                     got.cytoplasmic_volume, got.total_volume,
                     got.fluid_share, got.calcified_share, got.goal_cytoplasmic_solid);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    long_hold_req = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_TIME_STEP;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_regs = '{32'd1536, '0, '0, '0, '0, 32'd49152, '0, '0};
    foreach (loaded_map[i]) loaded_map[i] = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_load_extremes();
    test_step_special();
    test_output_backpressure();
    test_sender_pause();
    test_random_phase(3, 400);
    test_random_phase(1, 300);
    test_random_phase(0, 300);
    test_random_phase(2, 300);
    test_random_phase(4, 700);

    while (pending_volumes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_volumes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
